### src/msc_pkg.sv
// shared types and constants for the min_square_count block
// used by msc_ctrl, msc_datapath and the top level; no dependencies
package msc_pkg;

  localparam int N_BITS_DEF = 31;
  localparam int COUNT_W    = 3;

  localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_FOUR  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_CHECK,
    ST_PAIR,
    ST_LEG
  } state_t;

  typedef struct packed {
    logic               load;
    logic               root_step;
    logic               pair_init;
    logic               pair_step;
    logic               leg_step;
    logic               res_we;
    logic [COUNT_W-1:0] res_code;
  } msc_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic root_last;
    logic is_square;
    logic pair_over;
    logic pair_hit;
    logic leg_div4;
    logic leg_seven;
  } msc_status_t;

endpackage

### src/min_square_count.sv
// min_square_count top level: least number of positive squares summing to n
// instantiates msc_ctrl and msc_datapath; depends on msc_pkg
//
// One item at a time: in_value_n is taken in one transfer (low N_BITS bits
// used) and out_square_count (1 to 4) follows after R = ceil(N_BITS/2) root
// steps, a two-pointer pass bounded by r = floor(sqrt(n)) (one pointer move
// per cycle through one add and compare), and a final residue test that
// strips the factors of four; perfect squares and sums of two squares finish
// early. An input of zero answers 4. The output register holds a result
// while the next item is taken and worked on.
module min_square_count #(
  parameter int N_BITS = msc_pkg::N_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [N_BITS-1:0]           in_value_n,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [msc_pkg::COUNT_W-1:0] out_square_count
);

  msc_pkg::msc_cmd_t    cmd;
  msc_pkg::msc_status_t status;

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  msc_datapath #(
    .N_BITS (N_BITS)
  ) u_datapath (
    .clk              (clk),
    .in_value_n       (in_value_n),
    .cmd              (cmd),
    .status           (status),
    .out_square_count (out_square_count)
  );

endmodule

### src/msc_datapath.sv
// datapath: digit-by-digit square root, two-pointer search, 4^a(8b+7) test
// depends on msc_pkg for the command/status structs and count width
module msc_datapath #(
  parameter int N_BITS = msc_pkg::N_BITS_DEF
) (
  input  logic                        clk,
  input  logic [N_BITS-1:0]           in_value_n,
  input  msc_pkg::msc_cmd_t           cmd,
  output msc_pkg::msc_status_t        status,
  output logic [msc_pkg::COUNT_W-1:0] out_square_count
);

  localparam int R_W   = (N_BITS + 1) / 2;
  localparam int REM_W = R_W + 2;
  localparam int SQ_W  = 2 * R_W + 1;
  localparam int SUM_W = SQ_W + 1;
  localparam int CNT_W = $clog2(R_W);

  logic [N_BITS-1:0]           v_r;
  logic [2*R_W-1:0]            sh_r;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [R_W-1:0]              root_r, root_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic [R_W:0]                lo_r, hi_r;
  logic [SQ_W-1:0]             lo2_r, hi2_r;
  logic [N_BITS-1:0]           leg_r;
  logic [msc_pkg::COUNT_W-1:0] count_r;

  logic [REM_W+1:0] rt_cur, rt_trial, rt_diff;
  logic             rt_ge;
  logic [SUM_W-1:0] sum, v_ext;
  logic             sum_lt;

  // one result bit of the root per step
  always_comb begin
    rt_cur   = {rem_r, sh_r[2*R_W-1 -: 2]};
    rt_trial = {2'b00, root_r, 2'b01};
    rt_ge    = rt_cur >= rt_trial;
    rt_diff  = rt_cur - rt_trial;
    rem_nxt  = rt_ge ? rt_diff[REM_W-1:0] : rt_cur[REM_W-1:0];
    root_nxt = {root_r[R_W-2:0], rt_ge};
  end

  assign sum    = SUM_W'(lo2_r) + SUM_W'(hi2_r);
  assign v_ext  = SUM_W'(v_r);
  assign sum_lt = sum < v_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= in_value_n;
      sh_r   <= (2*R_W)'(in_value_n);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.root_step) begin
      sh_r   <= {sh_r[2*R_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (cmd.pair_init) begin
      lo_r  <= (R_W+1)'(1);
      hi_r  <= {1'b0, root_r};
      lo2_r <= SQ_W'(1);
      hi2_r <= SQ_W'(v_r - N_BITS'(rem_r));  // r*r without a multiplier
      leg_r <= v_r;
    end else if (cmd.pair_step) begin
      if (sum_lt) begin
        lo_r  <= lo_r + (R_W+1)'(1);
        lo2_r <= lo2_r + SQ_W'({lo_r, 1'b1});
      end else begin
        hi_r  <= hi_r - (R_W+1)'(1);
        hi2_r <= hi2_r - SQ_W'({hi_r, 1'b0}) + SQ_W'(1);
      end
    end else if (cmd.leg_step) begin
      leg_r <= {2'b00, leg_r[N_BITS-1:2]};
    end
    if (cmd.res_we) begin
      count_r <= cmd.res_code;
    end
  end

  always_comb begin
    status.is_zero   = v_r == '0;
    status.root_last = cnt_r == CNT_W'(R_W - 1);
    status.is_square = rem_r == '0;
    status.pair_over = lo_r > hi_r;
    status.pair_hit  = sum == v_ext;
    status.leg_div4  = leg_r[1:0] == 2'b00;
    status.leg_seven = leg_r[2:0] == 3'b111;
  end

  assign out_square_count = count_r;

`ifndef SYNTHESIS
  // running squares must track the pointers
  a_lo_square: assert property (@(posedge clk) cmd.pair_step |-> lo2_r == lo_r * lo_r)
    else $error("lo square out of step");
  a_hi_square: assert property (@(posedge clk) cmd.pair_step |-> hi2_r == hi_r * hi_r)
    else $error("hi square out of step");
  // finished root and remainder rebuild the operand
  a_root_exact: assert property (@(posedge clk)
    cmd.pair_init |-> N_BITS'({{R_W{1'b0}}, root_r} * {{R_W{1'b0}}, root_r})
                      + N_BITS'(rem_r) == v_r)
    else $error("root and remainder do not match operand");
`endif

endmodule

### src/msc_ctrl.sv
// controller state machine sequencing root, pair search and residue test
// depends on msc_pkg for state, command and status types
module msc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  msc_pkg::msc_status_t status,
  output msc_pkg::msc_cmd_t    cmd
);

  msc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != msc_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      msc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = msc_pkg::ST_ROOT;
        end
      end
      msc_pkg::ST_ROOT: begin
        if (status.is_zero) begin
          if (out_free) begin
            cmd.res_we   = 1'b1;
            cmd.res_code = msc_pkg::COUNT_FOUR;
            state_nxt    = msc_pkg::ST_IDLE;
          end
        end else begin
          cmd.root_step = 1'b1;
          if (status.root_last) begin
            state_nxt = msc_pkg::ST_CHECK;
          end
        end
      end
      msc_pkg::ST_CHECK: begin
        if (status.is_square) begin
          if (out_free) begin
            cmd.res_we   = 1'b1;
            cmd.res_code = msc_pkg::COUNT_ONE;
            state_nxt    = msc_pkg::ST_IDLE;
          end
        end else begin
          cmd.pair_init = 1'b1;
          state_nxt     = msc_pkg::ST_PAIR;
        end
      end
      msc_pkg::ST_PAIR: begin
        if (status.pair_over) begin
          state_nxt = msc_pkg::ST_LEG;
        end else if (status.pair_hit) begin
          if (out_free) begin
            cmd.res_we   = 1'b1;
            cmd.res_code = msc_pkg::COUNT_TWO;
            state_nxt    = msc_pkg::ST_IDLE;
          end
        end else begin
          cmd.pair_step = 1'b1;
        end
      end
      msc_pkg::ST_LEG: begin
        // strip factors of four, then check for 7 mod 8
        if (status.leg_div4) begin
          cmd.leg_step = 1'b1;
        end else if (out_free) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = status.leg_seven ? msc_pkg::COUNT_FOUR : msc_pkg::COUNT_THREE;
          state_nxt    = msc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = cmd.res_we || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_we |-> out_free)
    else $error("result written over a pending transfer");
  // a new result only appears after an item was worked on
  a_rise_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) != msc_pkg::ST_IDLE)
    else $error("result raised without an item in progress");
  // result codes stay in the 1 to 4 range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_we |-> (cmd.res_code == msc_pkg::COUNT_ONE || cmd.res_code == msc_pkg::COUNT_TWO ||
                    cmd.res_code == msc_pkg::COUNT_THREE || cmd.res_code == msc_pkg::COUNT_FOUR))
    else $error("bad result code");
`endif

endmodule
